// File: rtl/core/hvt_pkg.sv
// Package: hit volume table constants, record types and helpers.
`timescale 1ns / 1ps

package hvt_pkg;

   localparam int ENTRIES = 128;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam int COORD_W  = 24;
   localparam int RADIUS_W = 23;
   localparam int MASK_W   = 16;
   localparam int VERT_W   = COORD_W + 1;   // centre +/- radius, body top
   localparam int DIFF_W   = COORD_W + 1;   // absolute x / z distance
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int RSQ_W    = 2 * RADIUS_W;
   localparam int OUT_IDX_W = 7;

   // request kinds
   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   // response status codes
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_HIT      = 3'd2;
   localparam logic [2:0] ST_NOHIT    = 3'd3;
   localparam logic [2:0] ST_CLEARED  = 3'd4;

   // one stored volume
   typedef struct packed {
      logic [MASK_W-1:0]   mask;
      logic [RADIUS_W-1:0] radius;
      logic [COORD_W-1:0]  cz;
      logic [COORD_W-1:0]  cy;
      logic [COORD_W-1:0]  cx;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // query operands held for the whole scan
   typedef struct packed {
      logic [MASK_W-1:0]  mask;
      logic [VERT_W-1:0]  ut;
      logic [VERT_W-1:0]  ub;
      logic [COORD_W-1:0] pz;
      logic [COORD_W-1:0] px;
   } query_type;

   // slot address handed to the check unit together with the RAM read
   typedef struct packed {
      logic             valid;
      logic             live;
      logic [IDX_W-1:0] idx;
   } issue_type;

   // verdict on one slot, in slot order
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [IDX_W-1:0] idx;
   } verdict_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[OUT_IDX_W-1:0];
   endfunction

endpackage

// File: rtl/core/hvt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/hvt_check.sv
// Slot check unit: pipelined reach test, one stored volume per cycle.
`timescale 1ns / 1ps

module hvt_check
   import hvt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        flush,
   input  issue_type   issue,
   input  query_type   qry,
   input  entry_type   entry,
   output verdict_type verdict
);

   // stage 1 tag: lines up with RAM read data
   issue_type t1_ff, t1_in;

   // stage 2: distances, vertical bounds
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_cand_ff,  s2_cand_in;
   logic [IDX_W-1:0] s2_idx_ff;
   logic [DIFF_W-1:0] s2_dx_ff, s2_dz_ff, s2_dx_in, s2_dz_in;
   logic [RADIUS_W-1:0] s2_r_ff;
   logic signed [VERT_W-1:0] s2_bot_ff, s2_top_ff, s2_bot_in, s2_top_in;

   // stage 3: squares, vertical verdict
   logic             s3_valid_ff, s3_valid_in;
   logic             s3_cand_ff,  s3_cand_in;
   logic [IDX_W-1:0] s3_idx_ff;
   logic [SQ_W-1:0]  s3_dx2_ff, s3_dz2_ff;
   logic [RSQ_W-1:0] s3_r2_ff;

   logic signed [DIFF_W-1:0] dx_s, dz_s;
   logic signed [VERT_W-1:0] ub_s, ut_s, cy_s, r_s;
   logic                     vert_ok;
   logic [SQ_W:0]            dist2;

   assign t1_in = flush ? '0 : issue;

   // stage 1 -> 2
   always_comb begin
      dx_s = $signed({qry.px[COORD_W-1], qry.px}) - $signed({entry.cx[COORD_W-1], entry.cx});
      dz_s = $signed({qry.pz[COORD_W-1], qry.pz}) - $signed({entry.cz[COORD_W-1], entry.cz});
      s2_dx_in = dx_s[DIFF_W-1] ? DIFF_W'(-dx_s) : DIFF_W'(dx_s);
      s2_dz_in = dz_s[DIFF_W-1] ? DIFF_W'(-dz_s) : DIFF_W'(dz_s);
      cy_s = $signed({entry.cy[COORD_W-1], entry.cy});
      r_s  = $signed({2'b00, entry.radius});
      s2_bot_in = cy_s - r_s;
      s2_top_in = cy_s + r_s;
      s2_valid_in = t1_ff.valid && !flush;
      s2_cand_in  = t1_ff.live && ((entry.mask & qry.mask) != '0);
   end

   // stage 2 -> 3: four-way overlap rule
   always_comb begin
      ub_s = $signed(qry.ub);
      ut_s = $signed(qry.ut);
      vert_ok = (ut_s <= s2_top_ff && s2_bot_ff < ut_s) ||
                (ub_s <= s2_top_ff && s2_bot_ff < ub_s) ||
                (s2_top_ff <= ut_s && ub_s < s2_bot_ff) ||
                (ut_s <= s2_top_ff && s2_bot_ff < ub_s);
      s3_valid_in = s2_valid_ff && !flush;
      s3_cand_in  = s2_cand_ff && vert_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff       <= '0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         t1_ff       <= t1_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
      s2_cand_ff <= s2_cand_in;
      s2_idx_ff  <= t1_ff.idx;
      s2_dx_ff   <= s2_dx_in;
      s2_dz_ff   <= s2_dz_in;
      s2_r_ff    <= entry.radius;
      s2_bot_ff  <= s2_bot_in;
      s2_top_ff  <= s2_top_in;
      s3_cand_ff <= s3_cand_in;
      s3_idx_ff  <= s2_idx_ff;
      s3_dx2_ff  <= s2_dx_ff * s2_dx_ff;
      s3_dz2_ff  <= s2_dz_ff * s2_dz_ff;
      s3_r2_ff   <= s2_r_ff * s2_r_ff;
   end

   // stage 3: horizontal reach
   assign dist2 = {1'b0, s3_dx2_ff} + {1'b0, s3_dz2_ff};

   always_comb begin
      verdict.valid = s3_valid_ff;
      verdict.hit   = s3_cand_ff && (dist2 <= (SQ_W + 1)'(s3_r2_ff));
      verdict.idx   = s3_idx_ff;
   end

endmodule

// File: rtl/core/hit_volume_table_query.sv
// Top level: hit volume table with insert, query and clear.
`timescale 1ns / 1ps

// Table of ENTRIES spherical hit volumes (centre, radius, class mask) plus one
// valid flip-flop per slot. One request is handled at a time; req_tready is high
// while the sequencer is idle, even if the previous response is still waiting
// in the output register. Clear and the reserved request kind go straight
// from idle to the output state. Insert walks the valid bits one slot a
// cycle and stops at the first free one, or answers full after the last slot.
// Query streams the slots out of the volume RAM one a cycle into a three-stage
// check unit and stops at the first hit, or answers no hit after the last slot.
// A response waits in the output state while rsp_tready holds the output
// register. The scan order, lowest slot first, gives the lowest matching slot.
// Stored volumes sit in a single RAM, which has no reset; of the table state
// only the valid bits reset.

module hit_volume_table_query
   import hvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // [23:0] pos_x, [47:24] pos_y, [71:48] pos_z, [94:72] radius_in,
   // [117:95] height_in, [133:118] mask_bits, [135:134] zero
   input  logic [135:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]   req_tuser,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [6:0] entry_index, [7] zero
   output logic [7:0]   rsp_tdata,
   // [2:0] status
   output logic [2:0]   rsp_tuser
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_INSERT = 2'd1;
   localparam logic [1:0] S_QUERY  = 2'd2;
   localparam logic [1:0] S_OUT    = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               issuing_ff, issuing_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;

   entry_type          new_ff, new_in;        // volume to insert
   query_type          qry_ff, qry_in;        // query operands

   logic [2:0]         res_status_ff, res_status_in;
   logic [IDX_W-1:0]   res_idx_ff, res_idx_in;

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [OUT_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;

   logic               req_accept;
   logic               ram_wr_en, ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          ram_entry;
   issue_type          issue;
   verdict_type        verdict;
   logic               flush;

   logic [COORD_W-1:0]  in_px, in_py, in_pz;
   logic [RADIUS_W-1:0] in_radius, in_height;
   logic [MASK_W-1:0]   in_mask;

   assign in_px     = req_tdata[23:0];
   assign in_py     = req_tdata[47:24];
   assign in_pz     = req_tdata[71:48];
   assign in_radius = req_tdata[94:72];
   assign in_height = req_tdata[117:95];
   assign in_mask   = req_tdata[133:118];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      issuing_in    = issuing_ff;
      valid_in      = valid_ff;
      new_in        = new_ff;
      qry_in        = qry_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      issue         = '0;
      flush         = 1'b0;

      // output register drains independently of the sequencer
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               idx_in        = '0;
               res_idx_in    = '0;
               new_in.cx     = in_px;
               new_in.cy     = in_py;
               new_in.cz     = in_pz;
               new_in.radius = in_radius;
               new_in.mask   = in_mask;
               qry_in.px     = in_px;
               qry_in.pz     = in_pz;
               qry_in.ub     = {in_py[COORD_W-1], in_py};
               qry_in.ut     = VERT_W'($signed({in_py[COORD_W-1], in_py})
                                       + $signed({2'b00, in_height}));
               qry_in.mask   = in_mask;
               case (req_tuser)
                  REQ_CLEAR: begin
                     valid_in      = '0;
                     res_status_in = ST_CLEARED;
                     state_in      = S_OUT;
                  end
                  REQ_INSERT: begin
                     state_in = S_INSERT;
                  end
                  REQ_QUERY: begin
                     issuing_in = 1'b1;
                     state_in   = S_QUERY;
                  end
                  default: begin
                     res_status_in = ST_NOHIT;
                     state_in      = S_OUT;
                  end
               endcase
            end
         end

         S_INSERT: begin
            if (!valid_ff[idx_ff]) begin
               ram_wr_en        = 1'b1;
               valid_in[idx_ff] = 1'b1;
               res_status_in    = ST_INSERTED;
               res_idx_in       = idx_ff;
               state_in         = S_OUT;
            end else if (idx_ff == LAST_IDX) begin
               res_status_in = ST_FULL;
               state_in      = S_OUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_QUERY: begin
            // feed one slot a cycle into the check unit
            if (issuing_ff) begin
               ram_rd_en   = 1'b1;
               issue.valid = 1'b1;
               issue.live  = valid_ff[idx_ff];
               issue.idx   = idx_ff;
               if (idx_ff == LAST_IDX) begin
                  issuing_in = 1'b0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            // verdicts come back in slot order: first hit is the lowest slot
            if (verdict.valid && verdict.hit) begin
               res_status_in = ST_HIT;
               res_idx_in    = verdict.idx;
               issuing_in    = 1'b0;
               flush         = 1'b1;
               state_in      = S_OUT;
            end else if (verdict.valid && verdict.idx == LAST_IDX) begin
               res_status_in = ST_NOHIT;
               issuing_in    = 1'b0;
               flush         = 1'b1;
               state_in      = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = to_out_idx(res_idx_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issuing_ff    <= 1'b0;
         valid_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issuing_ff    <= issuing_in;
         valid_ff      <= valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      idx_ff        <= idx_in;
      new_ff        <= new_in;
      qry_ff        <= qry_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
   end

   hvt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_volume_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (idx_ff),
      .wr_data (new_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign ram_entry = entry_type'(ram_rd_data);

   hvt_check u_check (
      .clock   (clock),
      .reset   (reset),
      .flush   (flush),
      .issue   (issue),
      .qry     (qry_ff),
      .entry   (ram_entry),
      .verdict (verdict)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_idx_ff};

endmodule
